>>> hw/rtl/bia_pkg.sv
// ============================================================================
// bia_pkg
// Shared types, codes and helpers for the bitmap identifier allocator.
// ============================================================================
`default_nettype none

package bia_pkg;

   // Widths fixed by the request and response fields.
   localparam int ID_W          = 13;
   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_W         = 3;

   // A bitmap byte with every identifier in use.
   localparam logic [7:0] FULL_BYTE = 8'hFF;

   // Request codes carried in the request tuser bit.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Controller states.
   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREE,
      ST_SCAN
   } state_type;

   // Port strobes from the controller to the bitmap memory.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ram_ctl_type;

   // Index of the lowest clear bit of a byte that is known not to be full.
   function automatic logic [BIT_W-1:0] lowest_clear_bit(input logic [7:0] value);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
         if (!value[b]) begin
            idx = BIT_W'(b);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_id_allocator.sv
// ============================================================================
// bitmap_id_allocator
// Next-fit identifier allocator over a byte-wide bitmap memory.
// ============================================================================
// Identifiers are bits of a POOL_BYTES-byte bitmap held in a single-port-read,
// single-port-write memory with registered read data. After reset the block
// runs a clearing pass, one byte per cycle, during which req_tready stays low.
// A free issues the memory read with its transfer, then rewrites the byte and
// registers its result, so a new request is not taken until the free is done.
// An allocate reads one bitmap byte per cycle, starting from the window byte,
// while the output register is free, and steps over full bytes until it finds
// a clear bit; a scan over an exhausted pool reports failure once it has read
// every byte. A free or a scan waits while the output register still holds a
// result that has not been transferred. One request is in progress at a time,
// and a new request is taken while the previous result waits in the output
// register. Returned identifiers are byte * 8 + bit, cut to 13 bits.
`default_nettype none

module bitmap_id_allocator
   import bia_pkg::*;
#(
   parameter int POOL_BYTES = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [12:0] id_to_free, [15:13] zero
   input  wire logic [0:0]  req_tuser,   // [0] opcode
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [15:0] rsp_tdata,   // [12:0] id, [15:13] zero
   output logic      [0:0]  rsp_tuser    // [0] ok
);

   localparam int ADDR_W = (POOL_BYTES > 1) ? $clog2(POOL_BYTES) : 1;

   ram_ctl_type       ram_ctl;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic [7:0]        ram_rd_data;
   logic [ID_W-1:0]   rsp_id;
   logic              rsp_ok;

   // Sequencer and response register.
   bia_ctrl #(
      .POOL_BYTES (POOL_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_opcode  (req_tuser[0]),
      .req_id      (req_tdata[ID_W-1:0]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_ok      (rsp_ok),
      .rsp_id      (rsp_id),
      .ram_ctl     (ram_ctl),
      .ram_rd_addr (ram_rd_addr),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_data (ram_rd_data)
   );

   // Bitmap store.
   bia_bitmap_ram #(
      .POOL_BYTES (POOL_BYTES),
      .ADDR_W     (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .ctl     (ram_ctl),
      .rd_addr (ram_rd_addr),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // Result packing.
   assign rsp_tdata    = {3'b000, rsp_id};
   assign rsp_tuser[0] = rsp_ok;

endmodule

`default_nettype wire

>>> hw/rtl/bia_bitmap_ram.sv
// ============================================================================
// bia_bitmap_ram
// Bitmap store: one write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module bia_bitmap_ram
   import bia_pkg::*;
#(
   parameter int POOL_BYTES = 1024,
   parameter int ADDR_W     = 10
) (
   input  wire logic              clock,
   input  wire ram_ctl_type       ctl,
   input  wire logic [ADDR_W-1:0] rd_addr,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem_ff [POOL_BYTES];
   logic [7:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bia_ctrl.sv
// ============================================================================
// bia_ctrl
// Sequencer for clearing, allocate scans and frees, with the response register.
// ============================================================================
`default_nettype none

module bia_ctrl
   import bia_pkg::*;
#(
   parameter int POOL_BYTES = 1024,
   parameter int ADDR_W     = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // Request side.
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              req_opcode,
   input  wire logic [ID_W-1:0]   req_id,
   // Response side.
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_ok,
   output logic      [ID_W-1:0]   rsp_id,
   // Bitmap memory.
   output ram_ctl_type            ram_ctl,
   output logic      [ADDR_W-1:0] ram_rd_addr,
   output logic      [ADDR_W-1:0] ram_wr_addr,
   output logic      [7:0]        ram_wr_data,
   input  wire logic [7:0]        ram_rd_data
);

   localparam logic [ADDR_W-1:0] LAST_BYTE = ADDR_W'(POOL_BYTES - 1);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] window_ff, window_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [ADDR_W-1:0] start_ff, start_in;
   logic [ID_W-1:0]   req_id_ff, req_id_in;
   logic              in_range_ff, in_range_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;

   logic                         accept;
   logic                         slot_free;
   logic [ID_W-BIT_W-1:0]        free_byte;
   logic [BIT_W-1:0]             free_bit;
   logic                         free_in_range;
   logic [ADDR_W-1:0]            next_pos;
   logic [BIT_W-1:0]             alloc_bit;
   logic [ADDR_W+BIT_W-1:0]      alloc_id_full;

   // Decode of the incoming identifier and the scan helpers.
   assign accept        = req_valid && req_ready;
   assign slot_free     = !rsp_valid_ff || rsp_ready;
   assign free_byte     = req_id[ID_W-1:BIT_W];
   assign free_bit      = req_id_ff[BIT_W-1:0];
   assign free_in_range = 32'(free_byte) < 32'(POOL_BYTES);
   assign next_pos      = (pos_ff == LAST_BYTE) ? '0 : pos_ff + 1'b1;
   assign alloc_bit     = lowest_clear_bit(ram_rd_data);
   assign alloc_id_full = {pos_ff, alloc_bit};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_BYTE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_opcode == OP_FREE) ? ST_FREE : ST_SCAN;
            end
         end
         ST_FREE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (slot_free && (ram_rd_data != FULL_BYTE || next_pos == start_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Outputs and datapath updates.
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      ram_ctl       = '0;
      ram_rd_addr   = window_ff;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = '0;
      clr_in        = clr_ff;
      window_in     = window_ff;
      pos_in        = pos_ff;
      start_in      = start_ff;
      req_id_in     = req_id_ff;
      in_range_in   = in_range_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_id_in     = rsp_id_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_ctl.wr_en = 1'b1;
            ram_wr_addr   = clr_ff;
            clr_in        = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               ram_ctl.rd_en = 1'b1;
               req_id_in     = req_id;
               in_range_in   = free_in_range;
               if (req_opcode == OP_FREE) begin
                  ram_rd_addr = ADDR_W'(free_byte);
                  pos_in      = ADDR_W'(free_byte);
               end else begin
                  ram_rd_addr = window_ff;
                  pos_in      = window_ff;
                  start_in    = window_ff;
               end
            end
         end
         ST_FREE: begin
            if (slot_free) begin
               ram_ctl.wr_en = in_range_ff;
               ram_wr_data   = ram_rd_data & ~(8'b1 << free_bit);
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = 1'b1;
               rsp_id_in     = req_id_ff;
            end
         end
         ST_SCAN: begin
            if (slot_free) begin
               if (ram_rd_data != FULL_BYTE) begin
                  // Claim the lowest clear bit and park the window here.
                  ram_ctl.wr_en = 1'b1;
                  ram_wr_data   = ram_rd_data | (8'b1 << alloc_bit);
                  window_in     = pos_ff;
                  rsp_valid_in  = 1'b1;
                  rsp_ok_in     = 1'b1;
                  rsp_id_in     = ID_W'(alloc_id_full);
               end else if (next_pos == start_ff) begin
                  // Every byte is full.
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b0;
                  rsp_id_in    = '0;
               end else begin
                  ram_ctl.rd_en = 1'b1;
                  ram_rd_addr   = next_pos;
                  pos_in        = next_pos;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      start_ff    <= start_in;
      req_id_ff   <= req_id_in;
      in_range_ff <= in_range_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_id_ff   <= rsp_id_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_id    = rsp_id_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bia_checker.sv
// ============================================================================
// bia_checker
// Port-level checks for the bitmap identifier allocator, bound to its top.
// ============================================================================
`default_nettype none

module bia_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic [0:0]  rsp_tuser
);

   logic [1:0] open_ff, open_in;
   logic       req_xfer;
   logic       rsp_xfer;

   // Requests taken whose results have not yet been transferred.
   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   always_comb begin
      open_in = open_ff;
      if (req_xfer && !rsp_xfer) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_xfer && !req_xfer) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   // A stalled result holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Reset leaves neither channel active.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("channel active straight after reset");

   // A failed allocate reports identifier zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 16'd0)
      else $error("failed allocate with nonzero identifier");

   // Every result belongs to a request, and at most two are in flight.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || open_ff != 2'd0) && open_ff != 2'd3)
      else $error("result without request or too many open requests");

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);

`default_nettype wire
